// File: rtl/core/slcd_pkg.sv
`timescale 1ns / 1ps

package slcd_pkg;

  // Reset value of the sync register
  localparam logic [7:0] SyncReset = 8'h16;

  // Frame offset that carries the length byte
  localparam logic [8:0] LengthOffset = 9'd3;

  // Offset of the checksum byte is length plus this
  localparam logic [8:0] ChecksumOffsetAdd = 9'd4;

  // One classified frame byte on its way to the output
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic       checksum_ok;
  } item_t;

  // Write side of the queue between front and back
  typedef struct packed {
    logic  push;
    item_t data;
  } push_t;

endpackage

// File: rtl/core/sync_length_checksum_deframer.sv
`timescale 1ns / 1ps

// Sync / length / checksum deframer. Hunts the byte stream for the sync value
// (register, reset 0x16), takes the byte at offset 3 as length L and passes
// out the L+5 frame bytes with first/last marks; the last byte carries the
// verdict of comparing it with the 8-bit sum of offsets 1 to L+3. Bytes
// outside frames are dropped. One byte is accepted per clock cycle while the
// queue has room; a result is written to the queue at the edge that accepts
// its byte and shows on the output once the output register loads it from
// the queue. A stalled
// output fills the queue of QueueDepth entries before rx_ready_o drops. The
// sync register may be written at any time; a new value applies at the next
// hunt.
module sync_length_checksum_deframer #(
  parameter int QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       first_of_frame_o,
  output logic       last_of_frame_o,
  output logic       checksum_ok_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] sync_value_i
);
  import slcd_pkg::*;

  push_t push;
  item_t q_data;
  logic  q_full, q_avail, q_pop;

  // Classify bytes and track frame position
  slcd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (rx_valid_i),
    .rx_ready_o   (rx_ready_o),
    .rx_byte_i    (rx_byte_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .sync_value_i (sync_value_i),
    .q_full_i     (q_full),
    .push_o       (push)
  );

  // Decouple front from back
  slcd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .avail_o    (q_avail),
    .pop_data_o (q_data)
  );

  // Drive the output channel
  slcd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .avail_i          (q_avail),
    .data_i           (q_data),
    .pop_o            (q_pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .first_of_frame_o (first_of_frame_o),
    .last_of_frame_o  (last_of_frame_o),
    .checksum_ok_o    (checksum_ok_o)
  );

endmodule

// File: rtl/core/slcd_front.sv
`timescale 1ns / 1ps

module slcd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           rx_valid_i,
  output logic           rx_ready_o,
  input  logic [7:0]     rx_byte_i,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     sync_value_i,
  input  logic           q_full_i,
  output slcd_pkg::push_t push_o
);
  import slcd_pkg::*;

  logic [7:0] sync_value_q;
  logic       in_frame_q, in_frame_d;
  logic [8:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic [7:0] sum_q, sum_d;
  logic       accept;
  logic       is_last;
  logic       sync_hit;
  logic [8:0] last_pos;

  // Accept whenever the queue has room; configuration is always taken
  assign rx_ready_o  = ~q_full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = rx_valid_i & rx_ready_o;

  // Classify the incoming byte
  assign last_pos = {1'b0, len_q} + ChecksumOffsetAdd;
  assign is_last  = in_frame_q && (pos_q > LengthOffset) && (pos_q == last_pos);
  assign sync_hit = (rx_byte_i == sync_value_q);

  always_comb begin
    push_o.push                = accept & (in_frame_q | sync_hit);
    push_o.data.frame_byte     = rx_byte_i;
    push_o.data.first_of_frame = ~in_frame_q;
    push_o.data.last_of_frame  = is_last;
    push_o.data.checksum_ok    = is_last & (rx_byte_i == sum_q);
  end

  // Advance the frame tracker on each accepted byte
  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    len_d      = len_q;
    sum_d      = sum_q;
    if (accept) begin
      if (!in_frame_q) begin
        if (sync_hit) begin
          in_frame_d = 1'b1;
          pos_d      = 9'd1;
          sum_d      = 8'd0;
        end
      end else if (is_last) begin
        in_frame_d = 1'b0;
        pos_d      = 9'd0;
        sum_d      = 8'd0;
      end else begin
        if (pos_q == LengthOffset) begin
          len_d = rx_byte_i;
        end
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 9'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_value_q <= SyncReset;
      in_frame_q   <= 1'b0;
      pos_q        <= 9'd0;
      len_q        <= 8'd0;
      sum_q        <= 8'd0;
    end else begin
      if (cfg_valid_i) begin
        sync_value_q <= sync_value_i;
      end
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
    end
  end

  // A closing byte never opens a frame, and hunting resumes right after it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push && push_o.data.last_of_frame |-> !push_o.data.first_of_frame)
    else $error("front: byte marked both first and last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push && push_o.data.last_of_frame |=> !in_frame_q && pos_q == 9'd0)
    else $error("front: tracker not back to hunting after last byte");

endmodule

// File: rtl/core/slcd_queue.sv
`timescale 1ns / 1ps

module slcd_queue #(
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slcd_pkg::push_t  push_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             avail_o,
  output slcd_pkg::item_t  pop_data_o
);
  import slcd_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  item_t           mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o     = (count_q == DepthCnt);
  assign avail_o    = (count_q != '0);
  assign do_push    = push_i.push & ~full_o;
  assign do_pop     = pop_i & avail_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= DepthCnt)
    else $error("queue: fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push_i.push && full_o))
    else $error("queue: push while full, transaction lost");

endmodule

// File: rtl/core/slcd_back.sv
`timescale 1ns / 1ps

module slcd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            avail_i,
  input  slcd_pkg::item_t data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      frame_byte_o,
  output logic            first_of_frame_o,
  output logic            last_of_frame_o,
  output logic            checksum_ok_o
);
  import slcd_pkg::*;

  logic  valid_q;
  item_t data_q;

  // Load the output register when it is empty or being drained
  assign pop_o = avail_i & (~valid_q | out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Hold payload until the transaction completes
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o      = valid_q;
  assign frame_byte_o     = data_q.frame_byte;
  assign first_of_frame_o = data_q.first_of_frame;
  assign last_of_frame_o  = data_q.last_of_frame;
  assign checksum_ok_o    = data_q.checksum_ok;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && checksum_ok_o |-> last_of_frame_o)
    else $error("back: checksum verdict on a byte that is not last");

endmodule

// File: bench/sync_length_checksum_deframer_test.sv
`timescale 1ns / 1ps

module sync_length_checksum_deframer_test;
  import slcd_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int DrainPad      = 8;
  localparam int HoldOffCycles = 300;

  // Receiver stall patterns
  typedef enum int {
    ReadyAlways,
    ReadyCoin,
    ReadyMostly,
    ReadyRarely
  } ready_mode_e;

  // Tracks hunt/frame state and holds the frame bytes still owed by the block
  class deframe_tracker;
    logic [7:0] sync_byte = SyncReset;
    bit         in_frame = 1'b0;
    logic [8:0] position = '0;
    logic [7:0] length_byte = '0;
    logic [7:0] sum = '0;
    item_t      owed_q[$];
    int         errors = 0;

    function void set_sync(logic [7:0] value);
      sync_byte = value;
    endfunction

    // Work out the frame byte, if any, that one accepted rx transaction causes
    function void note_rx_byte(logic [7:0] rx);
      item_t want;
      want = '0;
      want.frame_byte = rx;
      if (!in_frame) begin
        // Hunt: drop everything but the sync byte
        if (rx == sync_byte) begin
          in_frame = 1'b1;
          position = 9'd1;
          sum = '0;
          want.first_of_frame = 1'b1;
          owed_q.push_back(want);
        end
      end else if (position > LengthOffset &&
                   position == {1'b0, length_byte} + ChecksumOffsetAdd) begin
        // Checksum byte closes the frame
        want.last_of_frame = 1'b1;
        want.checksum_ok = (rx == sum);
        in_frame = 1'b0;
        position = '0;
        sum = '0;
        owed_q.push_back(want);
      end else begin
        if (position == LengthOffset) begin
          length_byte = rx;
        end
        sum = sum + rx;
        position = position + 9'd1;
        owed_q.push_back(want);
      end
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one output transaction with the oldest owed frame byte
    function void check_frame_byte(item_t got);
      item_t want;
      if (owed_q.size() == 0) begin
        $error("frame_byte: expected no transaction, got %h", got.frame_byte);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      check_field("frame_byte", want.frame_byte, got.frame_byte);
      check_field("first_of_frame", 8'(want.first_of_frame), 8'(got.first_of_frame));
      check_field("last_of_frame", 8'(want.last_of_frame), 8'(got.last_of_frame));
      check_field("checksum_ok", 8'(want.checksum_ok), 8'(got.checksum_ok));
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       rx_valid_i = 1'b0;
  logic       rx_ready_o;
  logic [7:0] rx_byte_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] frame_byte_o;
  logic       first_of_frame_o;
  logic       last_of_frame_o;
  logic       checksum_ok_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] sync_value_i = '0;

  deframe_tracker tracker = new;
  item_t          seen_item;
  logic [7:0]     rx_plan[$];
  int             frame_bytes_planned = 0;
  int             burst_left = 0;
  bit             gapless = 1'b0;
  int             hold_req = 0;
  int             hold_served = 0;
  int             hold_left = 0;
  ready_mode_e    ready_mode = ReadyAlways;
  int             mode_left = 0;
  int             cycle_count = 0;

  sync_length_checksum_deframer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_byte_o     (frame_byte_o),
    .first_of_frame_o (first_of_frame_o),
    .last_of_frame_o  (last_of_frame_o),
    .checksum_ok_o    (checksum_ok_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .sync_value_i     (sync_value_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Check output transactions, then pick the next ready value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_item.frame_byte = frame_byte_o;
      seen_item.first_of_frame = first_of_frame_o;
      seen_item.last_of_frame = last_of_frame_o;
      seen_item.checksum_ok = checksum_ok_o;
      tracker.check_frame_byte(seen_item);
    end
    if (hold_req != hold_served) begin
      hold_served++;
      hold_left = HoldOffCycles;
    end
    if (hold_left > 0) begin
      // Long hold-off: let the block back up into its input
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (ready_mode)
        ReadyAlways: out_ready_i <= 1'b1;
        ReadyCoin:   out_ready_i <= 1'($urandom_range(0, 1));
        ReadyMostly: out_ready_i <= ($urandom_range(0, 7) != 0);
        default:     out_ready_i <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Append one frame: sync, two bytes, length, payload, checksum
  function automatic void add_frame(logic [7:0] sync, int len, bit corrupt);
    logic [7:0] b;
    logic [7:0] sum;
    sum = '0;
    rx_plan.push_back(sync);
    for (int i = 1; i < len + 4; i++) begin
      if (i == 3) begin
        b = len[7:0];
      end else begin
        b = ($urandom_range(0, 7) == 0) ? sync : 8'($urandom);
      end
      sum = sum + b;
      rx_plan.push_back(b);
    end
    rx_plan.push_back(corrupt ? sum ^ 8'($urandom_range(1, 255)) : sum);
    frame_bytes_planned += len + 5;
  endfunction

  // Append bytes between frames; garbage may contain the sync byte
  function automatic void add_noise(logic [7:0] sync, int n, bit garbage);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (!garbage && b == sync) begin
        b = ~sync;
      end
      rx_plan.push_back(b);
    end
  endfunction

  // Mostly well-formed frames of small length, some bad, some noise
  function automatic void add_traffic(logic [7:0] sync, int target);
    int start;
    int len;
    int r;
    start = frame_bytes_planned;
    while (frame_bytes_planned - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 2) begin
        len = $urandom_range(100, 255);
      end else if (r < 25) begin
        len = $urandom_range(9, 40);
      end else begin
        len = $urandom_range(0, 8);
      end
      add_frame(sync, len, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) begin
        add_noise(sync, $urandom_range(1, 6), 1'b0);
      end
      if ($urandom_range(0, 9) == 0) begin
        add_noise(sync, $urandom_range(1, 12), 1'b1);
      end
    end
  endfunction

  // Offer the planned bytes in bursts with random gaps, none when gapless is set
  task automatic send_plan();
    logic [7:0] b;
    int gap;
    while (rx_plan.size() != 0) begin
      b = rx_plan.pop_front();
      rx_valid_i <= 1'b1;
      rx_byte_i <= b;
      do begin
        @(posedge clk_i);
      end while (!rx_ready_o);
      tracker.note_rx_byte(b);
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(1, 48);
        gap = 0;
        if (!gapless && $urandom_range(0, 3) != 0) begin
          gap = $urandom_range(1, 8);
        end
        if (gap > 0) begin
          rx_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for every owed frame byte, then let the pipeline settle
  task automatic wait_drained();
    while (tracker.owed_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainPad) @(posedge clk_i);
  endtask

  task automatic write_sync(logic [7:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    sync_value_i <= value;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.set_sync(value);
  endtask

  initial begin
    logic [7:0] sync_plan[5];
    sync_plan = '{8'h5A, 8'hFF, 8'h16, 8'h00, 8'hC3};
    sync_plan[4] = 8'($urandom);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset sync value, noise, zero length, sync inside a frame,
    // bad checksum, wrapping sum, and a frame left open
    rx_plan = {8'h00, 8'hFF, 8'h15, 8'h17,
               8'h16, 8'h00, 8'hFF, 8'h00, 8'hFF,
               8'h16, 8'h16, 8'h80, 8'h02, 8'h16, 8'h7F, 8'h2C,
               8'h16, 8'hFF, 8'h01, 8'h00, 8'h00,
               8'h16, 8'h01, 8'h02};
    send_plan();

    // Change sync mid-frame: the open frame runs on with 0xFF inside it
    write_sync(8'hFF);
    rx_plan = {8'h03, 8'hA5, 8'h5A, 8'hFF, 8'h04};
    add_frame(8'hFF, 255, 1'b0);
    add_frame(8'hFF, 128, 1'b1);
    add_noise(8'hFF, 4, 1'b0);
    send_plan();

    // Pressure: receiver holds off while the sender keeps offering
    write_sync(8'h00);
    gapless = 1'b1;
    hold_req <= hold_req + 1;
    add_traffic(8'h00, 150);
    send_plan();
    gapless = 1'b0;

    // Random traffic under several sync values
    foreach (sync_plan[p]) begin
      write_sync(sync_plan[p]);
      add_traffic(sync_plan[p], 150);
      send_plan();
    end

    wait_drained();
    if (tracker.errors == 0 && tracker.owed_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
